// ===== hdl/assert_macros.svh =====
// Assertion macros for the walker module of the repeater
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Flag a condition that must never hold
`define AST_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition observed");
// Require a consequence in the cycle after a trigger
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("expected follow-up state missing");
`else
`define AST_NEVER(lbl, clk, rst_n, expr)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/gber_pkg.sv =====
// Shared types, constants and button map for the pad event repeater
`timescale 1ns / 1ps
package gber_pkg;

    localparam int PAD_COUNT    = 4;
    localparam int PAD_BITS     = 2;
    localparam int TIME_BITS    = 32;
    localparam int BTN_TOTAL    = 24;
    localparam int BTN_BITS     = 5;
    localparam int DL_DEPTH     = PAD_COUNT * BTN_TOTAL;
    localparam int DL_ADDR_BITS = $clog2(DL_DEPTH);
    localparam int CFG_BITS     = 16;
    localparam int IN_DATA_BITS = 168;
    localparam int OUT_DATA_BITS = 16;

    localparam logic [BTN_BITS-1:0] BTN_LAST = BTN_BITS'(BTN_TOTAL - 1);

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [BTN_TOTAL-1:0] t_flags;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_REPEAT  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CFG_INIT_DELAY  = 3'd0,
        CFG_REPEAT_IVL  = 3'd1,
        CFG_LEFT_DZ     = 3'd2,
        CFG_RIGHT_DZ    = 3'd3,
        CFG_TRIG_THRESH = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WALK  = 2'd1,
        ST_FLUSH = 2'd2
    } t_walk_state;

    typedef struct packed {
        logic                start;
        logic [PAD_BITS-1:0] pad;
        t_time               now;
        t_flags              old_flags;
        t_flags              new_flags;
    } t_walk_cmd;

    localparam logic [15:0] DIGITAL_MASK [BTN_TOTAL] = '{
        16'h1000, 16'h2000, 16'h8000, 16'h4000, 16'h0001, 16'h0002, 16'h0004, 16'h0008,
        16'h0100, 16'h0000, 16'h0040, 16'h0200, 16'h0000, 16'h0080, 16'h0010, 16'h0020,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

endpackage

// ===== hdl/gber_dl_ram.sv =====
// Deadline memory: one write port, one registered read port
`timescale 1ns / 1ps
module gber_dl_ram #(
    parameter int DEPTH     = 96,
    parameter int WIDTH     = 32,
    parameter int ADDR_BITS = 7
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gber_btn_map.sv =====
// Poll decoder: digital word, triggers and sticks to 24 virtual buttons
`timescale 1ns / 1ps
module gber_btn_map (
    input  logic [15:0]        i_button_bits,
    input  logic [7:0]         i_left_trigger,
    input  logic [7:0]         i_right_trigger,
    input  logic signed [15:0] i_left_x,
    input  logic signed [15:0] i_left_y,
    input  logic signed [15:0] i_right_x,
    input  logic signed [15:0] i_right_y,
    input  logic [7:0]         i_trig_thresh,
    input  logic [14:0]        i_left_dz,
    input  logic [14:0]        i_right_dz,
    output gber_pkg::t_flags   o_flags
);

    logic signed [16:0] lx, ly, rx, ry;
    logic signed [16:0] ldz, rdz;

    always_comb begin
        lx  = {i_left_x[15], i_left_x};
        ly  = {i_left_y[15], i_left_y};
        rx  = {i_right_x[15], i_right_x};
        ry  = {i_right_y[15], i_right_y};
        ldz = {2'b00, i_left_dz};
        rdz = {2'b00, i_right_dz};
        for (int b = 0; b < gber_pkg::BTN_TOTAL; b++) begin
            o_flags[b] = |(i_button_bits & gber_pkg::DIGITAL_MASK[b]);
        end
        if (i_left_trigger > i_trig_thresh) o_flags[9] = 1'b1;
        if (i_right_trigger > i_trig_thresh) o_flags[12] = 1'b1;
        o_flags[16] = ly > ldz;
        o_flags[17] = ly < -ldz;
        o_flags[18] = lx > ldz;
        o_flags[19] = lx < -ldz;
        o_flags[20] = ry > rdz;
        o_flags[21] = ry < -rdz;
        o_flags[22] = rx > rdz;
        o_flags[23] = rx < -rdz;
    end

endmodule

// ===== hdl/gber_walker.sv =====
// Button walker: read, update and write back deadlines, emit events in order
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gber_walker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gber_pkg::t_walk_cmd               i_cmd,
    input  logic [15:0]                       i_init_delay,
    input  logic [15:0]                       i_repeat_ivl,
    output logic                              o_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [gber_pkg::OUT_DATA_BITS-1:0] o_out_data,
    output logic                              o_out_last
);

    gber_pkg::t_walk_state r_state, n_state;

    logic [gber_pkg::PAD_BITS-1:0] r_pad;
    gber_pkg::t_time               r_now;
    gber_pkg::t_flags              r_old;
    gber_pkg::t_flags              r_new;
    logic [gber_pkg::BTN_BITS-1:0] r_rd_btn;
    logic                          r_s1_vld;
    logic [gber_pkg::BTN_BITS-1:0] r_s1_btn;

    logic                          r_pend_vld;
    logic [gber_pkg::BTN_BITS-1:0] r_pend_btn;
    gber_pkg::t_kind               r_pend_kind;

    logic                          r_out_vld;
    logic [gber_pkg::PAD_BITS-1:0] r_out_pad;
    logic [gber_pkg::BTN_BITS-1:0] r_out_btn;
    gber_pkg::t_kind               r_out_kind;
    logic                          r_out_last;

    logic                              out_free, adv, rd_issue, s1_act;
    logic                              was, isb, reached;
    logic                              evt_vld, dl_we, load_out;
    gber_pkg::t_kind                   evt_kind;
    gber_pkg::t_time                   dl_rdata, dl_wdata, diff;
    logic [gber_pkg::DL_ADDR_BITS-1:0] rd_addr, wr_addr, pad_base;

    gber_dl_ram #(
        .DEPTH     (gber_pkg::DL_DEPTH),
        .WIDTH     (gber_pkg::TIME_BITS),
        .ADDR_BITS (gber_pkg::DL_ADDR_BITS)
    ) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (wr_addr),
        .i_wdata (dl_wdata),
        .i_re    (rd_issue),
        .i_raddr (rd_addr),
        .o_rdata (dl_rdata)
    );

    always_comb begin
        out_free = !r_out_vld || i_out_ready;
        adv      = out_free || !r_pend_vld;
        rd_issue = (r_state == gber_pkg::ST_WALK) && adv &&
                   (r_rd_btn < gber_pkg::BTN_BITS'(gber_pkg::BTN_TOTAL));
        s1_act   = (r_state == gber_pkg::ST_WALK) && r_s1_vld && adv;
        pad_base = gber_pkg::DL_ADDR_BITS'(r_pad) *
                   gber_pkg::DL_ADDR_BITS'(gber_pkg::BTN_TOTAL);
        rd_addr  = pad_base + gber_pkg::DL_ADDR_BITS'(r_rd_btn);
        wr_addr  = pad_base + gber_pkg::DL_ADDR_BITS'(r_s1_btn);

        was      = r_old[r_s1_btn];
        isb      = r_new[r_s1_btn];
        diff     = r_now - dl_rdata;
        reached  = !diff[gber_pkg::TIME_BITS-1];
        evt_vld  = 1'b0;
        dl_we    = 1'b0;
        evt_kind = gber_pkg::KIND_PRESS;
        dl_wdata = r_now + gber_pkg::TIME_BITS'(i_init_delay);
        if (!was && isb) begin
            evt_vld = 1'b1;
            dl_we   = 1'b1;
        end else if (was && !isb) begin
            evt_vld  = 1'b1;
            evt_kind = gber_pkg::KIND_RELEASE;
        end else if (was && isb && reached) begin
            evt_vld  = 1'b1;
            dl_we    = 1'b1;
            evt_kind = gber_pkg::KIND_REPEAT;
            dl_wdata = r_now + gber_pkg::TIME_BITS'(i_repeat_ivl);
        end
        evt_vld = evt_vld && s1_act;
        dl_we   = dl_we && s1_act;

        load_out = ((r_state == gber_pkg::ST_WALK) && evt_vld && r_pend_vld) ||
                   ((r_state == gber_pkg::ST_FLUSH) && r_pend_vld && out_free);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gber_pkg::ST_IDLE: begin
                if (i_cmd.start) n_state = gber_pkg::ST_WALK;
            end
            gber_pkg::ST_WALK: begin
                if (s1_act && (r_s1_btn == gber_pkg::BTN_LAST)) n_state = gber_pkg::ST_FLUSH;
            end
            gber_pkg::ST_FLUSH: begin
                if (!r_pend_vld || out_free) n_state = gber_pkg::ST_IDLE;
            end
            default: n_state = gber_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gber_pkg::ST_IDLE;
            r_rd_btn   <= '0;
            r_s1_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cmd.start) begin
                r_rd_btn <= '0;
                r_s1_vld <= 1'b0;
            end else if ((r_state == gber_pkg::ST_WALK) && adv) begin
                r_s1_vld <= rd_issue;
                if (rd_issue) r_rd_btn <= r_rd_btn + 1'b1;
            end
            if (evt_vld) begin
                r_pend_vld <= 1'b1;
            end else if (load_out) begin
                r_pend_vld <= 1'b0;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pad <= i_cmd.pad;
            r_now <= i_cmd.now;
            r_old <= i_cmd.old_flags;
            r_new <= i_cmd.new_flags;
        end
        if ((r_state == gber_pkg::ST_WALK) && adv) begin
            r_s1_btn <= r_rd_btn;
        end
        if (load_out) begin
            r_out_pad  <= r_pad;
            r_out_btn  <= r_pend_btn;
            r_out_kind <= r_pend_kind;
            r_out_last <= (r_state == gber_pkg::ST_FLUSH);
        end
        if (evt_vld) begin
            r_pend_btn  <= r_s1_btn;
            r_pend_kind <= evt_kind;
        end
    end

    assign o_ready     = (r_state == gber_pkg::ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = {7'b0, r_out_kind, r_out_btn, r_out_pad};
    assign o_out_last  = r_out_last;

    `AST_NEVER(a_s1_outside_walk, i_clk, i_rst_n, r_s1_vld && (r_state != gber_pkg::ST_WALK))
    `AST_NEVER(a_pend_at_idle, i_clk, i_rst_n, r_pend_vld && (r_state == gber_pkg::ST_IDLE))
    `AST_NEVER(a_start_busy, i_clk, i_rst_n, i_cmd.start && (r_state != gber_pkg::ST_IDLE))
    `AST_NEXT(a_walk_fill, i_clk, i_rst_n, i_cmd.start, (r_state == gber_pkg::ST_WALK) && !r_s1_vld && (r_rd_btn == '0))

endmodule

// ===== hdl/gamepad_button_event_repeater_unit.sv =====
// Top level of the pad button event repeater
//
// Takes one poll beat of one of four pads, maps it onto 24 virtual buttons and
// emits pressed, released and repeated events in button order, with tlast on the
// final event of the poll. A poll whose packet number matches the one stored for
// its pad is taken and gives no events. A fresh poll walks all 24 buttons through
// the deadline memory behind its registered read, one button per cycle when the
// output side keeps up; a beat that the output holds while another event is
// waiting stalls the walk. The result register lets a new poll be taken while
// the last event of the previous one still waits.
`timescale 1ns / 1ps
module gamepad_button_event_repeater_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // lowest bit up: pad_index, button_bits, left_trigger, right_trigger, left_x,
    // left_y, right_x, right_y, packet_number, now_ticks, zero fill
    input  logic [gber_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // lowest bit up: event_pad, event_button, event_kind, zero fill
    output logic [gber_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_idx,
    input  logic [gber_pkg::CFG_BITS-1:0]       i_cfg_wdata
);

    logic [15:0] r_init_delay;
    logic [15:0] r_repeat_ivl;
    logic [14:0] r_left_dz;
    logic [14:0] r_right_dz;
    logic [7:0]  r_trig_thresh;

    gber_pkg::t_flags r_held [gber_pkg::PAD_COUNT];
    logic [31:0]      r_last_pkt [gber_pkg::PAD_COUNT];

    logic [gber_pkg::PAD_BITS-1:0] in_pad;
    logic [31:0]                   in_pkt;
    logic [31:0]                   in_now;
    logic                          accept, pad_ok, fresh;
    gber_pkg::t_flags              poll_flags;
    gber_pkg::t_walk_cmd           cmd;
    logic                          walk_ready;

    assign in_pad = s_axis_tdata[1:0];
    assign in_pkt = s_axis_tdata[129:98];
    assign in_now = s_axis_tdata[161:130];

    gber_btn_map u_btn_map (
        .i_button_bits   (s_axis_tdata[17:2]),
        .i_left_trigger  (s_axis_tdata[25:18]),
        .i_right_trigger (s_axis_tdata[33:26]),
        .i_left_x        (s_axis_tdata[49:34]),
        .i_left_y        (s_axis_tdata[65:50]),
        .i_right_x       (s_axis_tdata[81:66]),
        .i_right_y       (s_axis_tdata[97:82]),
        .i_trig_thresh   (r_trig_thresh),
        .i_left_dz       (r_left_dz),
        .i_right_dz      (r_right_dz),
        .o_flags         (poll_flags)
    );

    always_comb begin
        accept        = s_axis_tvalid && walk_ready;
        pad_ok        = int'(in_pad) < gber_pkg::PAD_COUNT;
        fresh         = in_pkt != r_last_pkt[in_pad];
        cmd.start     = accept && pad_ok && fresh;
        cmd.pad       = in_pad;
        cmd.now       = gber_pkg::TIME_BITS'(in_now);
        cmd.old_flags = r_held[in_pad];
        cmd.new_flags = poll_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_delay  <= 16'd300;
            r_repeat_ivl  <= 16'd100;
            r_left_dz     <= 15'd7849;
            r_right_dz    <= 15'd8689;
            r_trig_thresh <= 8'd30;
        end else if (i_cfg_we) begin
            unique case (gber_pkg::t_cfg_idx'(i_cfg_idx))
                gber_pkg::CFG_INIT_DELAY:  r_init_delay  <= i_cfg_wdata;
                gber_pkg::CFG_REPEAT_IVL:  r_repeat_ivl  <= i_cfg_wdata;
                gber_pkg::CFG_LEFT_DZ:     r_left_dz     <= i_cfg_wdata[14:0];
                gber_pkg::CFG_RIGHT_DZ:    r_right_dz    <= i_cfg_wdata[14:0];
                gber_pkg::CFG_TRIG_THRESH: r_trig_thresh <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < gber_pkg::PAD_COUNT; p++) begin
                r_held[p]     <= '0;
                r_last_pkt[p] <= '0;
            end
        end else if (cmd.start) begin
            r_held[in_pad]     <= poll_flags;
            r_last_pkt[in_pad] <= in_pkt;
        end
    end

    gber_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_init_delay (r_init_delay),
        .i_repeat_ivl (r_repeat_ivl),
        .o_ready      (walk_ready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

    assign s_axis_tready = walk_ready;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the pad button event repeater: random polls, event prediction, compare
`timescale 1ns / 1ps
module tb_top;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int VB_L2 = 9;
    localparam int VB_R2 = 12;
    localparam int VB_LS_UP = 16;
    localparam int VB_LS_DOWN = 17;
    localparam int VB_LS_RIGHT = 18;
    localparam int VB_LS_LEFT = 19;
    localparam int VB_RS_UP = 20;
    localparam int VB_RS_DOWN = 21;
    localparam int VB_RS_RIGHT = 22;
    localparam int VB_RS_LEFT = 23;

    typedef struct packed {
        logic [31:0]        now;
        logic [31:0]        packet;
        logic signed [15:0] ry;
        logic signed [15:0] rx;
        logic signed [15:0] ly;
        logic signed [15:0] lx;
        logic [7:0]         rt;
        logic [7:0]         lt;
        logic [15:0]        buttons;
        logic [1:0]         pad;
    } t_poll;

    typedef struct {
        logic [1:0]      pad;
        logic [4:0]      button;
        gber_pkg::t_kind kind;
        logic            last;
    } t_pad_event;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic [gber_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [gber_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic m_axis_tlast;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [gber_pkg::CFG_BITS-1:0] i_cfg_wdata = '0;

    gamepad_button_event_repeater_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // mirror of the block's state and registers
    logic [15:0] delay_ticks = 16'd300;
    logic [15:0] interval_ticks = 16'd100;
    logic [14:0] left_deadzone = 15'd7849;
    logic [14:0] right_deadzone = 15'd8689;
    logic [7:0]  trig_threshold = 8'd30;
    gber_pkg::t_flags held_mirror [gber_pkg::PAD_COUNT] = '{default: '0};
    logic [31:0] deadline_mirror [gber_pkg::PAD_COUNT][gber_pkg::BTN_TOTAL];
    logic [31:0] packet_mirror [gber_pkg::PAD_COUNT] = '{default: '0};

    t_poll      poll_backlog [$];
    t_pad_event pending_events [$];
    int         fault_count = 0;

    // generator state
    gber_pkg::t_flags pad_pattern [gber_pkg::PAD_COUNT] = '{default: '0};
    logic [31:0] sent_packet [gber_pkg::PAD_COUNT] = '{default: '0};
    logic [31:0] tick_now = 32'd5000;

    function automatic logic [15:0] button_mask(input int b);
        case (b)
            0: return 16'h1000;
            1: return 16'h2000;
            2: return 16'h8000;
            3: return 16'h4000;
            4: return 16'h0001;
            5: return 16'h0002;
            6: return 16'h0004;
            7: return 16'h0008;
            8: return 16'h0100;
            10: return 16'h0040;
            11: return 16'h0200;
            13: return 16'h0080;
            14: return 16'h0010;
            15: return 16'h0020;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic void predict_events(input t_poll p);
        gber_pkg::t_flags fresh;
        gber_pkg::t_flags prior;
        int lxv;
        int lyv;
        int rxv;
        int ryv;
        int ldz;
        int rdz;
        int b;
        int hits;
        logic [31:0] gap;
        t_pad_event ev;
        if (p.packet == packet_mirror[p.pad]) return;
        packet_mirror[p.pad] = p.packet;
        lxv = $signed(p.lx);
        lyv = $signed(p.ly);
        rxv = $signed(p.rx);
        ryv = $signed(p.ry);
        ldz = left_deadzone;
        rdz = right_deadzone;
        fresh = '0;
        for (b = 0; b < gber_pkg::BTN_TOTAL; b++) begin
            if ((p.buttons & button_mask(b)) != 16'h0000) fresh[b] = 1'b1;
        end
        fresh[VB_L2] = p.lt > trig_threshold;
        fresh[VB_R2] = p.rt > trig_threshold;
        fresh[VB_LS_UP] = lyv > ldz;
        fresh[VB_LS_DOWN] = lyv < -ldz;
        fresh[VB_LS_RIGHT] = lxv > ldz;
        fresh[VB_LS_LEFT] = lxv < -ldz;
        fresh[VB_RS_UP] = ryv > rdz;
        fresh[VB_RS_DOWN] = ryv < -rdz;
        fresh[VB_RS_RIGHT] = rxv > rdz;
        fresh[VB_RS_LEFT] = rxv < -rdz;
        prior = held_mirror[p.pad];
        hits = 0;
        for (b = 0; b < gber_pkg::BTN_TOTAL; b++) begin
            ev.pad = p.pad;
            ev.button = b[4:0];
            ev.last = 1'b0;
            if (!prior[b] && fresh[b]) begin
                ev.kind = gber_pkg::KIND_PRESS;
                deadline_mirror[p.pad][b] = p.now + {16'd0, delay_ticks};
                pending_events.push_back(ev);
                hits++;
            end else if (prior[b] && !fresh[b]) begin
                ev.kind = gber_pkg::KIND_RELEASE;
                pending_events.push_back(ev);
                hits++;
            end else if (prior[b] && fresh[b]) begin
                gap = p.now - deadline_mirror[p.pad][b];
                if (!gap[31]) begin
                    ev.kind = gber_pkg::KIND_REPEAT;
                    deadline_mirror[p.pad][b] = p.now + {16'd0, interval_ticks};
                    pending_events.push_back(ev);
                    hits++;
                end
            end
        end
        held_mirror[p.pad] = fresh;
        if (hits > 0) pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    // driver
    t_poll next_poll;
    t_poll r_shown_poll;
    int    r_send_gap = 0;
    bit    r_send_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            r_send_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (r_send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                r_send_gap <= r_send_gap - 1;
            end else if (poll_backlog.size() > 0) begin
                next_poll = poll_backlog.pop_front();
                r_shown_poll <= next_poll;
                s_axis_tdata <= {6'd0, next_poll};
                s_axis_tvalid <= 1'b1;
                r_send_gap <= r_send_calm ? 0 : int'($urandom_range(18, 0));
                if ($urandom_range(15, 0) == 0) r_send_calm <= !r_send_calm;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    int recv_draw;
    int r_recv_wait = 0;
    bit r_recv_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            r_recv_wait <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            recv_draw = r_recv_calm ? 0 : int'($urandom_range(18, 0));
            m_axis_tready <= (recv_draw == 0);
            r_recv_wait <= recv_draw;
            if ($urandom_range(15, 0) == 0) r_recv_calm <= !r_recv_calm;
        end else if (r_recv_wait > 0) begin
            r_recv_wait <= r_recv_wait - 1;
            m_axis_tready <= (r_recv_wait == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: check the event beat first, then predict from the poll beat
    always @(posedge i_clk) begin : monitor
        t_pad_event want;
        t_pad_event seen;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.pad = m_axis_tdata[1:0];
                seen.button = m_axis_tdata[6:2];
                seen.kind = gber_pkg::t_kind'(m_axis_tdata[8:7]);
                seen.last = m_axis_tlast;
                if (pending_events.size() == 0) begin
                    $display({"%0t: unexpected event, expected none, ",
                              "got pad %0d button %0d kind %0d last %0d"},
                             $time, seen.pad, seen.button, seen.kind, seen.last);
                    fault_count++;
                end else begin
                    want = pending_events.pop_front();
                    if (seen.pad !== want.pad || seen.button !== want.button ||
                        seen.kind !== want.kind || seen.last !== want.last) begin
                        $display({"%0t: event mismatch, ",
                                  "expected pad %0d button %0d kind %0d last %0d, ",
                                  "got pad %0d button %0d kind %0d last %0d"},
                                 $time, want.pad, want.button, want.kind, want.last,
                                 seen.pad, seen.button, seen.kind, seen.last);
                        fault_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_events(r_shown_poll);
        end
    end

    int r_quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            r_quiet_cycles <= 0;
        end else if (r_quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            r_quiet_cycles <= r_quiet_cycles + 1;
        end
    end

    task automatic queue_poll(input int pad, input logic [15:0] buttons,
                              input int lt, input int rt,
                              input int lx, input int ly, input int rx, input int ry,
                              input logic [31:0] packet, input logic [31:0] now);
        t_poll p;
        p.pad = pad[1:0];
        p.buttons = buttons;
        p.lt = lt[7:0];
        p.rt = rt[7:0];
        p.lx = lx[15:0];
        p.ly = ly[15:0];
        p.rx = rx[15:0];
        p.ry = ry[15:0];
        p.packet = packet;
        p.now = now;
        poll_backlog.push_back(p);
    endtask

    task automatic wait_idle();
        while (poll_backlog.size() != 0 || s_axis_tvalid || pending_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input gber_pkg::t_cfg_idx idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        case (idx)
            gber_pkg::CFG_INIT_DELAY: delay_ticks = value;
            gber_pkg::CFG_REPEAT_IVL: interval_ticks = value;
            gber_pkg::CFG_LEFT_DZ: left_deadzone = value[14:0];
            gber_pkg::CFG_RIGHT_DZ: right_deadzone = value[14:0];
            gber_pkg::CFG_TRIG_THRESH: trig_threshold = value[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] axis_value(input bit pos, input bit neg,
                                               input logic [14:0] dz);
        int d;
        int v;
        d = dz;
        if (pos) v = (d == 32767) ? 32767 : int'($urandom_range(32767, d + 1));
        else if (neg) v = -int'($urandom_range(32768, d + 1));
        else v = int'($urandom_range(2 * d, 0)) - d;
        return v[15:0];
    endfunction

    function automatic logic [7:0] trigger_value(input bit on, input logic [7:0] thr);
        if (on) return (thr == 8'd255) ? 8'd255 : 8'($urandom_range(255, int'(thr) + 1));
        return 8'($urandom_range(int'(thr), 0));
    endfunction

    function automatic t_poll shape_poll(input logic [1:0] pad, input gber_pkg::t_flags pattern,
                                         input logic [31:0] packet, input logic [31:0] now);
        t_poll p;
        int b;
        p.pad = pad;
        p.buttons = 16'($urandom) & 16'h0C00;
        for (b = 0; b < gber_pkg::BTN_TOTAL; b++) begin
            if (pattern[b]) p.buttons = p.buttons | button_mask(b);
        end
        p.lt = trigger_value(pattern[VB_L2], trig_threshold);
        p.rt = trigger_value(pattern[VB_R2], trig_threshold);
        p.ly = axis_value(pattern[VB_LS_UP], pattern[VB_LS_DOWN], left_deadzone);
        p.lx = axis_value(pattern[VB_LS_RIGHT], pattern[VB_LS_LEFT], left_deadzone);
        p.ry = axis_value(pattern[VB_RS_UP], pattern[VB_RS_DOWN], right_deadzone);
        p.rx = axis_value(pattern[VB_RS_RIGHT], pattern[VB_RS_LEFT], right_deadzone);
        p.packet = packet;
        p.now = now;
        return p;
    endfunction

    task automatic run_phase(input logic [15:0] delay, input logic [15:0] interval,
                             input logic [14:0] ldz, input logic [14:0] rdz,
                             input logic [7:0] thr, input int step_hi, input int fresh_total);
        int made;
        int pick;
        logic [1:0] pad;
        logic [31:0] packet;
        gber_pkg::t_flags flip;
        t_poll p;
        wait_idle();
        write_reg(gber_pkg::CFG_INIT_DELAY, delay);
        write_reg(gber_pkg::CFG_REPEAT_IVL, interval);
        write_reg(gber_pkg::CFG_LEFT_DZ, {1'b0, ldz});
        write_reg(gber_pkg::CFG_RIGHT_DZ, {1'b0, rdz});
        write_reg(gber_pkg::CFG_TRIG_THRESH, {8'd0, thr});
        made = 0;
        while (made < fresh_total) begin
            pad = 2'($urandom_range(3, 0));
            pick = $urandom_range(99, 0);
            tick_now = tick_now + 32'($urandom_range(step_hi, 0));
            if (pick < 78) begin
                flip = 24'($urandom & $urandom & $urandom);
                pad_pattern[pad] = pad_pattern[pad] ^ flip;
                packet = ($urandom_range(7, 0) == 0) ? 32'($urandom) : sent_packet[pad] + 1;
                p = shape_poll(pad, pad_pattern[pad], packet, tick_now);
            end else if (pick < 88) begin
                // same packet number: must be dropped whatever it carries
                p = shape_poll(pad, 24'($urandom), sent_packet[pad], tick_now);
            end else begin
                if ($urandom_range(2, 0) == 0) tick_now = $urandom;
                p.pad = pad;
                p.buttons = 16'($urandom);
                p.lt = 8'($urandom);
                p.rt = 8'($urandom);
                p.lx = 16'($urandom);
                p.ly = 16'($urandom);
                p.rx = 16'($urandom);
                p.ry = 16'($urandom);
                p.packet = $urandom;
                p.now = tick_now;
            end
            if (p.packet != sent_packet[pad]) made++;
            sent_packet[pad] = p.packet;
            poll_backlog.push_back(p);
        end
    endtask

    initial begin
        // reset settings: first poll with packet zero is dropped, then extremes
        queue_poll(0, 16'hFFFF, 255, 255, 32767, -32768, -32768, 32767, 0, 1000);
        queue_poll(0, 16'hFFFF, 255, 255, 32767, -32768, -32768, 32767, 1, 1000);
        queue_poll(0, 16'hFFFF, 255, 255, 32767, -32768, -32768, 32767, 1, 5000);
        queue_poll(0, 16'hFFFF, 255, 255, 32767, -32768, -32768, 32767, 2, 1299);
        queue_poll(0, 16'hFFFF, 255, 255, 32767, -32768, -32768, 32767, 3, 1300);
        queue_poll(0, 16'hFFFF, 255, 255, 32767, -32768, -32768, 32767, 4, 1399);
        queue_poll(0, 16'hFFFF, 255, 255, 32767, -32768, -32768, 32767, 5, 1400);
        queue_poll(0, 16'h0000, 30, 30, 7849, -7849, 8689, -8689, 6, 1500);
        queue_poll(0, 16'h0000, 31, 31, -7850, 7850, 8690, -8690, 7, 1600);
        queue_poll(0, 16'h0000, 0, 0, 0, 0, 0, 0, 8, 1700);
        queue_poll(1, 16'h1000, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        queue_poll(1, 16'h1000, 0, 0, 0, 0, 0, 0, 0, 32'h0000_011B);
        queue_poll(1, 16'h1000, 0, 0, 0, 0, 0, 0, 1, 32'h0000_011C);
        queue_poll(1, 16'h0000, 0, 0, 0, 0, 0, 0, 2, 32'h0000_0200);
        queue_poll(2, 16'h8421, 0, 0, -32768, 32767, 32767, -32768, 32'hA5A5_A5A5, 32'h200);
        queue_poll(3, 16'h0C00, 0, 0, 0, 0, 0, 0, 1, 32'h210);
        queue_poll(3, 16'h0C80, 0, 0, 0, 0, 0, 0, 2, 32'h220);
        queue_poll(2, 16'h0000, 0, 0, 0, 0, 0, 0, 32'h5A5A_5A5A, 32'h8000_0300);
        queue_poll(3, 16'h0000, 0, 0, 0, 0, 0, 0, 3, 32'h8000_0400);
        sent_packet[0] = 8;
        sent_packet[1] = 2;
        sent_packet[2] = 32'h5A5A_5A5A;
        sent_packet[3] = 3;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(16'd0, 16'd0, 15'd0, 15'd0, 8'd0, 3, 45);
        run_phase(16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 8'hFF, 40000, 45);
        run_phase(16'($urandom_range(400, 50)), 16'($urandom_range(150, 10)),
                  15'($urandom), 15'($urandom), 8'($urandom), 120, 45);
        tick_now = 32'hFFFF_F000;
        run_phase(16'd300, 16'd100, 15'd7849, 15'd8689, 8'd30, 150, 45);
        run_phase(16'd1, 16'hFFFF, 15'd1, 15'd1, 8'd254, 50, 45);

        wait_idle();
        if (pending_events.size() != 0) fault_count++;
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
